[hdl/tcw_pkg.sv]
// Package for the text console writer: screen geometry, derived widths,
// request and result structs, command and state encodings.
// No dependencies.
package tcw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int COL_W  = $clog2(SCREEN_COLUMNS);

  // Fixed field widths of the request and result.
  localparam int KIND_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;
  localparam int WORD_W    = 16;

  // Column sum for a cursor advance, quotient of that sum by the width,
  // total rows to advance and the row after the advance.
  localparam int SUM_W  = ((COL_W > BYTE_W) ? COL_W : BYTE_W) + 1;
  localparam int QUO_W  = SUM_W;
  localparam int ADV_W  = SUM_W + 1;
  localparam int NEXT_W = ((ADV_W > ROW_W) ? ADV_W : ROW_W) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  localparam logic [KIND_W-1:0] KIND_PUT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CR      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SCROLL  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  char_code;
    logic [BYTE_W-1:0]  row_count;
    logic [BYTE_W-1:0]  column_count;
    logic [BYTE_W-1:0]  scroll_lines;
    logic [INDEX_W-1:0] cell_index;
  } request_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_column;
    logic [WORD_W-1:0]    cell_word;
  } result_t;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_CR,
    OP_ADVANCE,
    OP_SCROLL,
    OP_CLEAR,
    OP_READ,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] row_count;
    logic [BYTE_W-1:0] column_count;
    logic [BYTE_W-1:0] scroll_lines;
    logic [ADDR_W-1:0] addr;
    logic              hit;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_ADV,
    ST_SCROLL,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_RESP
  } back_state_t;

endpackage

[hdl/text_console_writer.sv]
// Top level of the text console writer: configuration register, front end,
// command queue and back end. Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back.
//
//   Port group      Direction  Handshake                         Payload
//   request         in         start high while busy is low       command (request_t)
//   result          out        result_valid, one cycle, no stall  result (result_t)
//   configuration   in/out     APB write in setup plus access     pwdata, prdata
//
// A put character, carriage return, read cell or unused command passes
// through the idle and response states of the back end, which takes the next
// command from the queue only once it is back in idle. A request taken by the
// front end goes through the front end register and the queue to the back end,
// whose response state registers the result strobe. A new line, or a put that
// wraps off the right edge, adds a row update state; an advance adds a division
// state, one subtraction per whole screen width in the column sum, and the row
// update. A scroll, or a new line or wrap on the bottom row, walks the cell
// store through its single write port one cell at a time; a clear walks all
// CELL_COUNT cells as well. After reset (synchronous, active high) a clearing
// pass writes blanks over all CELL_COUNT cells with busy held high; the
// configuration port works during that pass. Results cannot be held off.
module text_console_writer (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcw_pkg::request_t command,
  output logic              result_valid,
  output tcw_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tcw_pkg::*;

  // The colour attribute is the only register; it is selected when bit 2 of the
  // address is low, and the byte offset bits below it are ignored.
  logic [BYTE_W-1:0] attr;
  logic              cfg_write;
  logic              attr_sel;

  logic              hold;
  logic              push;
  logic              q_ready;
  logic              q_valid;
  logic              pop;
  cmd_t              front_cmd;
  cmd_t              head_cmd;

  assign pready    = 1'b1;
  assign attr_sel  = ~paddr[2];
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = attr_sel ? {{(32 - BYTE_W){1'b0}}, attr} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (cfg_write && attr_sel) begin
      attr <= pwdata[BYTE_W-1:0];
    end
  end

  // The front end decodes each request into a command and stalls only when
  // the queue is full or the store is still being cleared after reset.
  tcw_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .hold    (hold),
    .q_ready (q_ready),
    .busy    (busy),
    .push    (push),
    .cmd     (front_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .ready    (q_ready),
    .pop      (pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  // The back end owns the cell store and the cursor and registers every result.
  tcw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .attr         (attr),
    .q_valid      (q_valid),
    .q_cmd        (head_cmd),
    .pop          (pop),
    .initialising (hold),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[hdl/tcw_front.sv]
// Front end of the text console writer: takes requests, decodes them into
// commands and hands them to the command queue. Depends on tcw_pkg.
module tcw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tcw_pkg::request_t command,
  input  logic              hold,
  input  logic              q_ready,
  output logic              busy,
  output logic              push,
  output tcw_pkg::cmd_t     cmd
);
  import tcw_pkg::*;

  logic  f_valid;
  logic  f_valid_next;
  cmd_t  f_cmd;
  cmd_t  dec;
  logic  accept;

  assign push   = f_valid & q_ready;
  assign busy   = hold | (f_valid & ~q_ready);
  assign accept = start & ~busy;
  assign cmd    = f_cmd;

  always_comb begin
    dec.char_code    = command.char_code;
    dec.row_count    = command.row_count;
    dec.column_count = command.column_count;
    dec.scroll_lines = command.scroll_lines;
    dec.addr         = ADDR_W'(command.cell_index);
    dec.hit          = 32'(command.cell_index) < 32'(CELL_COUNT);
    unique case (command.kind)
      KIND_PUT:     dec.op = OP_PUT;
      KIND_NEWLINE: dec.op = OP_NEWLINE;
      KIND_CR:      dec.op = OP_CR;
      KIND_ADVANCE: dec.op = OP_ADVANCE;
      KIND_SCROLL:  dec.op = OP_SCROLL;
      KIND_CLEAR:   dec.op = OP_CLEAR;
      KIND_READ:    dec.op = OP_READ;
      default:      dec.op = OP_NONE;
    endcase
    f_valid_next = accept | (f_valid & ~push);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd <= dec;
    end
  end

endmodule

[hdl/tcw_queue.sv]
// Short command queue between the front end and the back end of the text
// console writer. Depends on tcw_pkg.
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output tcw_pkg::cmd_t head
);
  import tcw_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign ready   = count != QCNT_W'(QUEUE_DEPTH);
  assign valid   = count != '0;
  assign head    = slots[rptr];
  assign do_push = push & ready;
  assign do_pop  = pop & valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      if (do_push & ~do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop & ~do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_cmd;
    end
  end

endmodule

[hdl/tcw_back.sv]
// Back end of the text console writer: owns the cell store and the cursor,
// and runs each command to completion. Depends on tcw_pkg.
module tcw_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tcw_pkg::BYTE_W-1:0] attr,
  input  logic                      q_valid,
  input  tcw_pkg::cmd_t             q_cmd,
  output logic                      pop,
  output logic                      initialising,
  output logic                      result_valid,
  output tcw_pkg::result_t          result
);
  import tcw_pkg::*;

  logic [WORD_W-1:0] mem [CELL_COUNT];
  logic [WORD_W-1:0] rdata;

  back_state_t       state, state_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [SUM_W-1:0]  sum, sum_next;
  logic [QUO_W-1:0]  quo, quo_next;
  logic [ADV_W-1:0]  adv, adv_next;
  logic [NEXT_W-1:0] lines, lines_next;
  logic              bottom, bottom_next;
  logic [ADDR_W-1:0] off, off_next;
  logic              pend, pend_next;
  logic [ADDR_W-1:0] pptr, pptr_next;
  logic              hit, hit_next;
  result_t           res, res_next;
  logic              res_valid, res_valid_next;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [COL_W:0]    col_inc;
  logic [NEXT_W-1:0] row_sum;
  logic [WORD_W-1:0] blank;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

  assign initialising = state == ST_INIT;
  assign result_valid = res_valid;
  assign result       = res;
  assign blank        = {attr, SPACE_CHAR};
  assign col_inc      = {1'b0, col} + (COL_W + 1)'(1);
  assign row_sum      = NEXT_W'(row) + NEXT_W'(adv);

  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    row_next       = row;
    col_next       = col;
    sum_next       = sum;
    quo_next       = quo;
    adv_next       = adv;
    lines_next     = lines;
    bottom_next    = bottom;
    off_next       = off;
    pend_next      = 1'b0;
    pptr_next      = pptr;
    hit_next       = hit;
    res_next       = res;
    res_valid_next = 1'b0;
    we             = 1'b0;
    waddr          = ptr;
    wdata          = blank;
    raddr          = ptr;
    pop            = 1'b0;

    unique case (state)
      ST_INIT: begin
        we    = 1'b1;
        wdata = {RESET_ATTR, SPACE_CHAR};
        if (ptr == LAST_CELL) begin
          ptr_next   = '0;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (q_valid) begin
          pop         = 1'b1;
          hit_next    = 1'b0;
          bottom_next = 1'b0;
          unique case (q_cmd.op)
            OP_PUT: begin
              we    = 1'b1;
              waddr = ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col));
              wdata = {attr, q_cmd.char_code};
              if (col_inc == (COL_W + 1)'(SCREEN_COLUMNS)) begin
                col_next   = '0;
                adv_next   = ADV_W'(1);
                state_next = ST_ADV;
              end else begin
                col_next   = COL_W'(col_inc);
                state_next = ST_RESP;
              end
            end
            OP_NEWLINE: begin
              col_next   = '0;
              adv_next   = ADV_W'(1);
              state_next = ST_ADV;
            end
            OP_CR: begin
              col_next   = '0;
              state_next = ST_RESP;
            end
            OP_ADVANCE: begin
              sum_next   = SUM_W'(col) + SUM_W'(q_cmd.column_count);
              quo_next   = '0;
              adv_next   = ADV_W'(q_cmd.row_count);
              state_next = ST_DIV;
            end
            OP_SCROLL: begin
              lines_next = NEXT_W'(q_cmd.scroll_lines);
              state_next = ST_SCROLL;
            end
            OP_CLEAR: begin
              ptr_next   = '0;
              state_next = ST_FILL;
            end
            OP_READ: begin
              raddr      = q_cmd.addr;
              hit_next   = q_cmd.hit;
              state_next = ST_RESP;
            end
            default: begin
              state_next = ST_RESP;
            end
          endcase
        end
      end

      // Column sum split into whole rows and a column, one subtraction a step.
      ST_DIV: begin
        if (sum >= SUM_W'(SCREEN_COLUMNS)) begin
          sum_next = sum - SUM_W'(SCREEN_COLUMNS);
          quo_next = quo + QUO_W'(1);
        end else begin
          col_next   = COL_W'(sum);
          adv_next   = adv + ADV_W'(quo);
          state_next = ST_ADV;
        end
      end

      ST_ADV: begin
        if (row_sum >= NEXT_W'(SCREEN_ROWS)) begin
          lines_next  = row_sum - NEXT_W'(SCREEN_ROWS) + NEXT_W'(1);
          bottom_next = 1'b1;
          state_next  = ST_SCROLL;
        end else begin
          row_next   = ROW_W'(row_sum);
          state_next = ST_RESP;
        end
      end

      ST_SCROLL: begin
        ptr_next = '0;
        if (lines == '0) begin
          state_next = ST_RESP;
        end else if (lines >= NEXT_W'(SCREEN_ROWS)) begin
          row_next   = bottom ? ROW_W'(SCREEN_ROWS - 1) : '0;
          state_next = ST_FILL;
        end else begin
          if (bottom) begin
            row_next = ROW_W'(SCREEN_ROWS - 1);
          end else if (NEXT_W'(row) >= lines) begin
            row_next = row - ROW_W'(lines);
          end else begin
            row_next = '0;
          end
          off_next   = ADDR_W'(ADDR_W'(lines[ROW_W-1:0]) * ADDR_W'(SCREEN_COLUMNS));
          state_next = ST_COPY;
        end
      end

      // Read one cell ahead, write the cell read in the cycle before.
      ST_COPY: begin
        raddr     = ptr + off;
        we        = pend;
        waddr     = pptr;
        wdata     = rdata;
        pend_next = 1'b1;
        pptr_next = ptr;
        ptr_next  = ptr + ADDR_W'(1);
        if (raddr == LAST_CELL) begin
          state_next = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        we         = 1'b1;
        waddr      = pptr;
        wdata      = rdata;
        state_next = ST_FILL;
      end

      ST_FILL: begin
        we = 1'b1;
        if (ptr == LAST_CELL) begin
          state_next = ST_RESP;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end

      ST_RESP: begin
        res_next.cursor_row    = OUT_ROW_W'(row);
        res_next.cursor_column = OUT_COL_W'(col);
        res_next.cell_word     = hit ? rdata : '0;
        res_valid_next         = 1'b1;
        state_next             = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      ptr       <= '0;
      row       <= '0;
      col       <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      bottom    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      row       <= row_next;
      col       <= col_next;
      pend      <= pend_next;
      hit       <= hit_next;
      bottom    <= bottom_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sum   <= sum_next;
    quo   <= quo_next;
    adv   <= adv_next;
    lines <= lines_next;
    off   <= off_next;
    pptr  <= pptr_next;
    res   <= res_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
